>>> design/cycle_timing_monitor_core_defines.svh
// ------------------------------------------------------------------------
// Cycle timing monitor assertion macros
// Shared property shorthands for the checker, clocked on clk, held off
// while rst_n is low.
// ------------------------------------------------------------------------
`ifndef CYCLE_TIMING_MONITOR_CORE_DEFINES_SVH
`define CYCLE_TIMING_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cycle timing monitor: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define CTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cycle timing monitor: next-cycle check failed");

`endif

>>> design/ctm_pkg.sv
// ------------------------------------------------------------------------
// Cycle timing monitor package
// Payload types, configuration codes and fixed constants of the monitor.
// ------------------------------------------------------------------------
package ctm_pkg;

  // Slots that make up one scheduling cycle.
  localparam int unsigned SLOTS_PER_CYCLE = 4;

  // Threshold after reset, in microseconds.
  localparam logic [31:0] THRESHOLD_RESET = 32'd900000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MONITOR_ENABLE = 1'b0,
    CFG_THRESHOLD_USEC = 1'b1
  } ctm_cfg_idx_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic        monitor_enable;
    logic [31:0] threshold_usec;
  } ctm_cfg_t;

  // One slot report.
  typedef struct packed {
    logic [1:0]  slot_index;
    logic [31:0] slot_elapsed_usec;
  } ctm_slot_t;

  // One finished-cycle report.
  typedef struct packed {
    logic [31:0] cycle_number;
    logic [1:0]  slowest_slot_index;
    logic [31:0] slowest_slot_usec;
    logic [31:0] cycle_total_usec;
    logic [31:0] max_cycle_usec;
    logic        max_updated;
    logic        threshold_exceeded;
    logic [31:0] exceed_count;
  } ctm_result_t;

endpackage

>>> design/ctm_if.sv
// ------------------------------------------------------------------------
// Cycle timing monitor channels
// Valid/ready channels for slot reports in and cycle reports out.
// ------------------------------------------------------------------------
interface ctm_in_if;
  import ctm_pkg::*;

  logic      valid;
  logic      ready;
  ctm_slot_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctm_out_if;
  import ctm_pkg::*;

  logic        valid;
  logic        ready;
  ctm_result_t data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

>>> design/ctm_in_stage.sv
// ------------------------------------------------------------------------
// Cycle timing monitor input stage
// Registers one slot beat and hands it to the update stage.
// ------------------------------------------------------------------------
module ctm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  ctm_in_if.sink            in_ch,
  input  logic              advance,
  output logic              s1_valid,
  output ctm_pkg::ctm_slot_t s1_data
);
  import ctm_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  ctm_slot_t data_r;
  logic      load;

  // Take a beat when the register is empty or drains this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until the next beat.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_ch.data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

>>> design/ctm_update.sv
// ------------------------------------------------------------------------
// Cycle timing monitor update stage
// Folds one slot into the open cycle and registers the cycle report.
// ------------------------------------------------------------------------
module ctm_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  ctm_pkg::ctm_slot_t s1_data,
  input  ctm_pkg::ctm_cfg_t  cfg,
  output logic               advance,
  ctm_out_if.source          out_ch
);
  import ctm_pkg::*;

  // Cycle state
  logic        cycle_open_r,   cycle_open_nxt;
  logic [31:0] cycle_counter_r, cycle_counter_nxt;
  logic [31:0] running_total_r, running_total_nxt;
  logic [1:0]  slowest_index_r, slowest_index_nxt;
  logic [31:0] slowest_time_r,  slowest_time_nxt;
  logic [31:0] max_total_r,     max_total_nxt;
  logic [31:0] exceed_counter_r, exceed_counter_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  ctm_result_t out_data_r;
  ctm_result_t result;

  logic        process;
  logic        open_new;
  logic        last_slot;
  logic [31:0] base_total;
  logic [31:0] base_time;
  logic [1:0]  base_index;
  logic [32:0] sum;
  logic        raised;
  logic        exceeded;

  // Drain the input stage whenever the result register can take a beat.
  assign advance = !out_valid_r || out_ch.ready;
  assign process = s1_valid && advance;

  // Slot zero or a closed cycle starts fresh.
  assign open_new   = !cycle_open_r || (s1_data.slot_index == 2'd0);
  assign base_total = open_new ? 32'd0 : running_total_r;
  assign base_time  = open_new ? 32'd0 : slowest_time_r;
  assign base_index = open_new ? 2'd0 : slowest_index_r;
  assign last_slot  = (7'(s1_data.slot_index) + 7'd1) == 7'(SLOTS_PER_CYCLE);

  always_comb begin
    cycle_counter_nxt  = open_new ? cycle_counter_r + 32'd1 : cycle_counter_r;

    // Saturating accumulate.
    sum               = {1'b0, base_total} + {1'b0, s1_data.slot_elapsed_usec};
    running_total_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    // Later slot wins a tie.
    if (s1_data.slot_elapsed_usec >= base_time) begin
      slowest_time_nxt  = s1_data.slot_elapsed_usec;
      slowest_index_nxt = s1_data.slot_index;
    end else begin
      slowest_time_nxt  = base_time;
      slowest_index_nxt = base_index;
    end

    raised        = running_total_nxt > max_total_r;
    max_total_nxt = max_total_r;
    if (last_slot && raised) begin
      max_total_nxt = running_total_nxt;
    end

    exceeded           = cfg.monitor_enable && (running_total_nxt >= cfg.threshold_usec);
    exceed_counter_nxt = exceed_counter_r;
    if (last_slot && exceeded && (exceed_counter_r != 32'hFFFF_FFFF)) begin
      exceed_counter_nxt = exceed_counter_r + 32'd1;
    end

    cycle_open_nxt = !last_slot;

    result.cycle_number       = cycle_counter_nxt;
    result.slowest_slot_index = slowest_index_nxt;
    result.slowest_slot_usec  = slowest_time_nxt;
    result.cycle_total_usec   = running_total_nxt;
    result.max_cycle_usec     = max_total_nxt;
    result.max_updated        = raised;
    result.threshold_exceeded = exceeded;
    result.exceed_count       = exceed_counter_nxt;
  end

  // Result valid: set on a finishing slot, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (process && last_slot) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Advance the cycle state one slot at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_open_r     <= 1'b0;
      cycle_counter_r  <= 32'd0;
      running_total_r  <= 32'd0;
      slowest_index_r  <= 2'd0;
      slowest_time_r   <= 32'd0;
      max_total_r      <= 32'd0;
      exceed_counter_r <= 32'd0;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (process) begin
        cycle_open_r     <= cycle_open_nxt;
        cycle_counter_r  <= cycle_counter_nxt;
        running_total_r  <= running_total_nxt;
        slowest_index_r  <= slowest_index_nxt;
        slowest_time_r   <= slowest_time_nxt;
        max_total_r      <= max_total_nxt;
        exceed_counter_r <= exceed_counter_nxt;
      end
    end
  end

  // Hold the report until the next finishing slot.
  always_ff @(posedge clk) begin
    if (process && last_slot) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

>>> design/cycle_timing_monitor_core.sv
// ------------------------------------------------------------------------
// Cycle timing monitor core
// Per-cycle slot timing totals, slowest slot, running maximum and
// threshold exceed counting for a fixed-slot scheduler.
// ------------------------------------------------------------------------
// Takes one slot report per clock and returns one report for every cycle
// whose last slot arrives. A slot beat passes an input register and one
// update stage that holds the cycle state, and the report is registered
// once the update stage folds in the last slot's beat; a new slot beat is
// taken in every clock as long as the result register is free or being
// read. The update path is one 32-bit saturating add followed by the
// maximum and threshold compares. Configuration writes take effect on the
// next clock and are expected only while no slot is in flight.
module cycle_timing_monitor_core (
  input  logic                  clk,
  input  logic                  rst_n,
  ctm_in_if.sink                in_ch,
  ctm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  ctm_pkg::ctm_cfg_idx_t cfg_index,
  input  logic [31:0]           cfg_wdata
);
  import ctm_pkg::*;

  logic        monitor_enable_r;
  logic [31:0] threshold_usec_r;
  ctm_cfg_t    cfg;
  logic        advance;
  logic        s1_valid;
  ctm_slot_t   s1_data;

  // Configuration registers; a zero threshold is stored as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_enable_r <= 1'b0;
      threshold_usec_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MONITOR_ENABLE: begin
          monitor_enable_r <= cfg_wdata[0];
        end
        CFG_THRESHOLD_USEC: begin
          threshold_usec_r <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.monitor_enable = monitor_enable_r;
  assign cfg.threshold_usec = threshold_usec_r;

  ctm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  ctm_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .cfg      (cfg),
    .advance  (advance),
    .out_ch   (out_ch)
  );

endmodule

>>> design/ctm_checker.sv
// ------------------------------------------------------------------------
// Cycle timing monitor checker
// Port-level checks on the cycle report channel, bound to the core.
// ------------------------------------------------------------------------
`include "cycle_timing_monitor_core_defines.svh"

module ctm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input ctm_pkg::ctm_result_t out_data
);
  import ctm_pkg::*;

  logic [31:0] total_usec;
  logic [31:0] max_usec;
  logic [31:0] slow_usec;
  logic [31:0] exceed_cnt;

  assign total_usec = out_data.cycle_total_usec;
  assign max_usec   = out_data.max_cycle_usec;
  assign slow_usec  = out_data.slowest_slot_usec;
  assign exceed_cnt = out_data.exceed_count;

  // A stalled report stays put.
  `CTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // The running maximum covers this cycle's total.
  `CTM_ASSERT_NOW(a_max_covers, out_valid, max_usec >= total_usec)

  // A raised maximum equals this cycle's total.
  `CTM_ASSERT_NOW(a_max_raised, out_valid && out_data.max_updated, max_usec == total_usec)

  // The slowest slot never exceeds the saturating sum.
  `CTM_ASSERT_NOW(a_slow_le_total, out_valid, slow_usec <= total_usec)

  // An exceeded cycle has been counted.
  `CTM_ASSERT_NOW(a_exceed_counted, out_valid && out_data.threshold_exceeded, exceed_cnt != 32'd0)

endmodule

bind cycle_timing_monitor_core ctm_checker u_ctm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

>>> sim/ctm_report_checker.sv
// ------------------------------------------------------------------------
// Cycle report checker
// Watches slot beats and cycle reports, folds each slot into its own copy
// of the cycle state and compares every report field by field.
// ------------------------------------------------------------------------
module ctm_report_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  ctm_in_if                     in_mon,
  ctm_out_if.monitor            out_mon,
  input  logic                  cfg_we,
  input  ctm_pkg::ctm_cfg_idx_t cfg_index,
  input  logic [31:0]           cfg_wdata,
  output int unsigned           mismatch_count,
  output int unsigned           reports_pending
);
  import ctm_pkg::*;

  // Shadow configuration
  logic        enable_q;
  logic [31:0] threshold_q;

  // Shadow cycle state
  logic        open_q;
  logic [31:0] cycle_cnt_q;
  logic [31:0] total_q;
  logic [1:0]  slow_idx_q;
  logic [31:0] slow_time_q;
  logic [31:0] max_total_q;
  logic [31:0] exceed_cnt_q;

  ctm_result_t pending_cycle_reports[$];

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Fold one slot beat into the cycle; queue a report when the cycle ends
  task automatic fold_slot_report(input ctm_slot_t beat);
    ctm_result_t rpt;
    if (!open_q || beat.slot_index == 2'd0) begin
      open_q      = 1'b1;
      cycle_cnt_q = cycle_cnt_q + 32'd1;
      total_q     = '0;
      slow_idx_q  = '0;
      slow_time_q = '0;
    end
    total_q = sat_sum(total_q, beat.slot_elapsed_usec);
    if (beat.slot_elapsed_usec >= slow_time_q) begin
      slow_time_q = beat.slot_elapsed_usec;
      slow_idx_q  = beat.slot_index;
    end
    if (int'(beat.slot_index) + 1 == SLOTS_PER_CYCLE) begin
      rpt.max_updated = 1'b0;
      if (total_q > max_total_q) begin
        max_total_q     = total_q;
        rpt.max_updated = 1'b1;
      end
      rpt.threshold_exceeded = 1'b0;
      if (enable_q && total_q >= threshold_q) begin
        rpt.threshold_exceeded = 1'b1;
        if (exceed_cnt_q != '1) exceed_cnt_q = exceed_cnt_q + 32'd1;
      end
      rpt.cycle_number       = cycle_cnt_q;
      rpt.slowest_slot_index = slow_idx_q;
      rpt.slowest_slot_usec  = slow_time_q;
      rpt.cycle_total_usec   = total_q;
      rpt.max_cycle_usec     = max_total_q;
      rpt.exceed_count       = exceed_cnt_q;
      pending_cycle_reports.push_back(rpt);
      open_q = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_report(input ctm_result_t want, input ctm_result_t got);
    check_field("cycle_number", want.cycle_number, got.cycle_number);
    check_field("slowest_slot_index", 32'(want.slowest_slot_index),
                32'(got.slowest_slot_index));
    check_field("slowest_slot_usec", want.slowest_slot_usec, got.slowest_slot_usec);
    check_field("cycle_total_usec", want.cycle_total_usec, got.cycle_total_usec);
    check_field("max_cycle_usec", want.max_cycle_usec, got.max_cycle_usec);
    check_field("max_updated", 32'(want.max_updated), 32'(got.max_updated));
    check_field("threshold_exceeded", 32'(want.threshold_exceeded),
                32'(got.threshold_exceeded));
    check_field("exceed_count", want.exceed_count, got.exceed_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      enable_q       = 1'b0;
      threshold_q    = THRESHOLD_RESET;
      open_q         = 1'b0;
      cycle_cnt_q    = '0;
      total_q        = '0;
      slow_idx_q     = '0;
      slow_time_q    = '0;
      max_total_q    = '0;
      exceed_cnt_q   = '0;
      mismatch_count = 0;
      pending_cycle_reports.delete();
    end else begin
      // Apply register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MONITOR_ENABLE: enable_q = cfg_wdata[0];
          CFG_THRESHOLD_USEC: threshold_q = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
          default: ;
        endcase
      end
      // Compare an accepted report beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (pending_cycle_reports.size() == 0) begin
          $error("cycle report beat with no report expected");
          mismatch_count++;
        end else begin
          compare_report(pending_cycle_reports.pop_front(), out_mon.data);
        end
      end
      // Advance the shadow state on an accepted slot beat
      if (in_mon.valid && in_mon.ready) fold_slot_report(in_mon.data);
    end
    reports_pending = pending_cycle_reports.size();
  end

endmodule

>>> sim/tb.sv
// ------------------------------------------------------------------------
// Cycle timing monitor testbench
// Drives directed and random slot reports through the monitor core with
// random idling on both channels, a long output stall and several
// register settings; the report checker predicts and compares.
// ------------------------------------------------------------------------
module tb;
  import ctm_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  ctm_cfg_idx_t cfg_index;
  logic [31:0]  cfg_wdata;
  int unsigned  mismatch_count;
  int unsigned  reports_pending;
  bit           steady;
  int unsigned  hold_request;

  ctm_in_if  in_ch ();
  ctm_out_if out_ch ();

  cycle_timing_monitor_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ctm_report_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .reports_pending(reports_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Report sink: random stalls, plus one long hold-off when requested
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0 && !hold_taken) begin
        hold_left  = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // Offer one slot beat and hold it until accepted
  task automatic send_slot(input logic [1:0] slot, input logic [31:0] usec);
    ctm_slot_t beat;
    beat.slot_index        = slot;
    beat.slot_elapsed_usec = usec;
    while (!steady && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly short times near the threshold, some extremes and wide values
  function automatic logic [31:0] pick_usec();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(400000);
    endcase
  endfunction

  // Well-formed cycles with random times, mixed with stray slots
  task automatic send_cycles(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_slot(2'($urandom_range(3)), pick_usec());
        sent++;
      end else begin
        for (int k = 0; k < SLOTS_PER_CYCLE; k++) begin
          send_slot(2'(k), pick_usec());
          sent++;
        end
      end
    end
  endtask

  // Drop valid and wait until every report is in and the pipe is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ctm_cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] en_word, input logic [31:0] thr,
                           input int unsigned n_items);
    write_reg(CFG_MONITOR_ENABLE, en_word);
    write_reg(CFG_THRESHOLD_USEC, thr);
    send_cycles(n_items);
    drain();
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_MONITOR_ENABLE;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    steady       = 1'b0;
    hold_request = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturating total, slowest slot in the middle
    send_slot(2'd0, 32'd0);
    send_slot(2'd1, 32'hFFFF_FFFF);
    send_slot(2'd2, 32'd0);
    send_slot(2'd3, 32'd1);
    // Equal times: the later slot wins
    for (int k = 0; k < 4; k++) send_slot(2'(k), 32'd5);
    // All-zero cycle
    for (int k = 0; k < 4; k++) send_slot(2'(k), 32'd0);
    // Last slot alone opens and finishes a cycle
    send_slot(2'd3, 32'd7);
    // Middle slot opens a cycle while none is open
    send_slot(2'd2, 32'd9);
    send_slot(2'd3, 32'd9);
    // Slot 0 mid-cycle restarts the cycle
    send_slot(2'd0, 32'd100);
    send_slot(2'd1, 32'd200);
    send_slot(2'd0, 32'd50);
    send_slot(2'd1, 32'd60);
    send_slot(2'd2, 32'd60);
    send_slot(2'd3, 32'd10);
    // Skipped and repeated slots
    send_slot(2'd0, 32'd300);
    send_slot(2'd2, 32'd300);
    send_slot(2'd2, 32'd1);
    send_slot(2'd3, 32'd2);
    drain();

    // Wide enable write, zero threshold stored as one
    write_reg(CFG_MONITOR_ENABLE, 32'hA5A5_A5A5);
    write_reg(CFG_THRESHOLD_USEC, 32'd0);
    for (int k = 0; k < 4; k++) send_slot(2'(k), 32'd0);
    for (int k = 0; k < 4; k++) send_slot(2'(k), (k == 2) ? 32'd1 : 32'd0);
    drain();

    // Top threshold: only a saturated total reaches it
    write_reg(CFG_THRESHOLD_USEC, 32'hFFFF_FFFF);
    send_slot(2'd0, 32'hFFFF_FFFF);
    send_slot(2'd3, 32'd0);
    send_slot(2'd0, 32'hFFFF_FFFE);
    send_slot(2'd3, 32'd0);
    drain();

    // Random phases over several settings
    run_phase(32'd1, THRESHOLD_RESET, 190);
    steady = 1'b1;
    run_phase(32'hFFFF_FFFE, $urandom, 190);
    steady = 1'b0;
    run_phase(32'd1, $urandom_range(2000000, 1), 190);
    run_phase(32'd1, 32'd1, 190);
    run_phase(32'd1, 32'hFFFF_FFFF, 190);

    // Long output hold-off while slots keep coming
    write_reg(CFG_THRESHOLD_USEC, 32'd1200000);
    hold_request = 300;
    send_cycles(60);
    drain();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/ctm_pkg.sv
design/ctm_if.sv
design/ctm_in_stage.sv
design/ctm_update.sv
design/cycle_timing_monitor_core.sv
design/ctm_checker.sv
sim/ctm_report_checker.sv
sim/tb.sv
